FILE: src/npr_pkg.sv
// shared types, constants and helpers of the nearest point to ray picker
package npr_pkg;

  localparam int GRID_SIDE = 4;
  localparam int NPTS      = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W     = $clog2(NPTS);
  localparam int QBITS     = 18;
  localparam int CNT_W     = $clog2(QBITS);
  localparam logic [31:0] THRESH_RESET = 32'd32768;
  localparam logic [31:0] DIST_MAX     = 32'hFFFF_FFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PICK  = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } point_t;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } npr_in_t;

  typedef struct packed {
    logic               found;
    logic [1:0]         hit_row;
    logic [1:0]         hit_col;
    logic signed [15:0] near_x;
    logic signed [15:0] near_y;
    logic signed [15:0] near_z;
    logic [31:0]        best_dist_sq;
  } npr_out_t;

  // bump surface after reset: interior points raised to 7.0, border at -3.0
  function automatic point_t reset_point(input logic [IDX_W-1:0] idx);
    int     i;
    int     j;
    logic   inner;
    point_t p;
    i = int'(idx) / GRID_SIDE;
    j = int'(idx) % GRID_SIDE;
    inner = (i > 0) && (i < GRID_SIDE - 1) && (j > 0) && (j < GRID_SIDE - 1);
    p.x = 16'((2 * i - (GRID_SIDE - 1)) * 256);
    p.y = 16'((2 * j - (GRID_SIDE - 1)) * 256);
    p.z = inner ? 16'(7 * 256) : 16'(-3 * 256);
    return p;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    logic [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: src/npr_ram.sv
// generic single write port ram with registered read
module npr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nearest_point_to_ray_picker.sv
// nearest point to ray picker: control point grid in ram, sequential ray pick
//
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | in_data (npr_in_t)
//  out     | output    | out_valid/stall | out_data (npr_out_t)
//  cfg     | input     | cfg_we          | cfg_wdata (pick threshold)
//
// a write beat goes straight into the ram. a pick with a nonzero direction
// visits all 16 grid points, then hands over the result: each point costs a
// ram read, two multiply steps and an 18 bit restoring divide (three dividers, one per axis).
// synchronous reset; grid entries never written read as the bump surface.
// a finished result waits in the output register; new beats are taken while
// it waits, and a later pick holds in its last state until the register frees.
module nearest_point_to_ray_picker
  import npr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  npr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output npr_out_t    out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_VMUL = 11'b000_0000_0010,
    ST_VSUM = 11'b000_0000_0100,
    ST_RD   = 11'b000_0000_1000,
    ST_DOT  = 11'b000_0001_0000,
    ST_PIR  = 11'b000_0010_0000,
    ST_PRD  = 11'b000_0100_0000,
    ST_DIV  = 11'b000_1000_0000,
    ST_DIST = 11'b001_0000_0000,
    ST_CMP  = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic               in_acc;
  logic               ram_we;
  logic [47:0]        ram_rdata;
  logic [NPTS-1:0]    vld_r;
  logic               vld_s_r;
  logic [31:0]        thr_r;
  logic               out_valid_r;
  npr_out_t           out_r;
  logic               out_load;

  logic signed [15:0] o_r [3];
  logic signed [15:0] v_r [3];
  logic [31:0]        vsq_r [3];
  logic [31:0]        vv_r;
  logic [IDX_W-1:0]   n_r;
  point_t             pt_r;
  point_t             pt_cur;
  logic signed [15:0] p_cur [3];
  logic signed [15:0] p_hold [3];
  logic signed [32:0] prod_r [3];
  logic signed [34:0] pir_r;
  logic [52:0]        rem_r [3];
  logic               neg_r [3];
  logic [QBITS-1:0]   q_r [3];
  logic [49:0]        ds_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [19:0] nr_r [3];
  logic [40:0]        sq_r [3];

  logic               have_r;
  logic [31:0]        best_r;
  logic signed [19:0] bn_r [3];
  logic [IDX_W-1:0]   bidx_r;

  logic [42:0]        dist_sum;
  logic [31:0]        dist_sat;
  logic               better;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign ram_we    = in_acc && (in_data.opcode == OP_WRITE) &&
                     (5'(in_data.point_index) < 5'(NPTS));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  npr_ram #(.WIDTH(48), .DEPTH(NPTS)) u_pts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.point_index[IDX_W-1:0]),
    .wdata ({in_data.point_x, in_data.point_y, in_data.point_z}),
    .raddr (n_r),
    .rdata (ram_rdata)
  );

  // entries never written read as the reset surface
  assign pt_cur   = vld_s_r ? point_t'(ram_rdata) : reset_point(n_r);
  assign p_cur[0] = pt_cur.x;
  assign p_cur[1] = pt_cur.y;
  assign p_cur[2] = pt_cur.z;
  assign p_hold[0] = pt_r.x;
  assign p_hold[1] = pt_r.y;
  assign p_hold[2] = pt_r.z;

  always_comb begin
    dist_sum = 43'(sq_r[0]) + 43'(sq_r[1]) + 43'(sq_r[2]);
    dist_sat = (dist_sum > 43'(DIST_MAX)) ? DIST_MAX : dist_sum[31:0];
    better   = (dist_sat < thr_r) && (!have_r || (dist_sat < best_r));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.opcode == OP_PICK)) begin
          state_nxt = ST_VMUL;
        end
      end
      ST_VMUL: state_nxt = ST_VSUM;
      ST_VSUM: state_nxt = ST_RD;
      ST_RD: begin
        state_nxt = (vv_r == 32'd0) ? ST_DONE : ST_DOT;
      end
      ST_DOT:  state_nxt = ST_PIR;
      ST_PIR:  state_nxt = ST_PRD;
      ST_PRD:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: state_nxt = ST_CMP;
      ST_CMP: begin
        state_nxt = (n_r == IDX_W'(NPTS - 1)) ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= THRESH_RESET;
      have_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (ram_we) begin
        vld_r[in_data.point_index[IDX_W-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        have_r <= 1'b0;
      end else if ((state_r == ST_CMP) && better) begin
        have_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      o_r[0] <= in_data.origin_x;
      o_r[1] <= in_data.origin_y;
      o_r[2] <= in_data.origin_z;
      v_r[0] <= in_data.dir_x;
      v_r[1] <= in_data.dir_y;
      v_r[2] <= in_data.dir_z;
      n_r    <= '0;
    end
    case (state_r)
      ST_VMUL: begin
        for (int k = 0; k < 3; k++) begin
          vsq_r[k] <= 32'(32'(v_r[k]) * 32'(v_r[k]));
        end
      end
      ST_VSUM: begin
        vv_r <= vsq_r[0] + vsq_r[1] + vsq_r[2];
      end
      ST_RD: begin
        vld_s_r <= vld_r[n_r];
      end
      ST_DOT: begin
        pt_r <= pt_cur;
        for (int k = 0; k < 3; k++) begin
          prod_r[k] <= (17'(p_cur[k]) - 17'(o_r[k])) * 33'(v_r[k]);
        end
      end
      ST_PIR: begin
        pir_r <= 35'(prod_r[0]) + 35'(prod_r[1]) + 35'(prod_r[2]);
      end
      ST_PRD: begin
        // rounded quotient = floor((2|num| + vv) / (2 vv)), fits 18 bits
        for (int k = 0; k < 3; k++) begin
          logic signed [50:0] num;
          logic [50:0]        mag;
          num = 51'(pir_r) * 51'(v_r[k]);
          mag = num[50] ? 51'(-num) : 51'(num);
          rem_r[k] <= (53'(mag) << 1) + 53'(vv_r);
          neg_r[k] <= num[50];
          q_r[k]   <= '0;
        end
        ds_r  <= 50'({vv_r, 1'b0}) << (QBITS - 1);
        cnt_r <= CNT_W'(QBITS - 1);
      end
      ST_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (rem_r[k] >= 53'(ds_r)) begin
            rem_r[k] <= rem_r[k] - 53'(ds_r);
            q_r[k]   <= {q_r[k][QBITS-2:0], 1'b1};
          end else begin
            q_r[k]   <= {q_r[k][QBITS-2:0], 1'b0};
          end
        end
        ds_r  <= ds_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      ST_DIST: begin
        for (int k = 0; k < 3; k++) begin
          logic signed [18:0] qs;
          logic signed [19:0] nr;
          logic signed [20:0] e;
          logic signed [41:0] e2;
          qs = neg_r[k] ? -19'(q_r[k]) : 19'(q_r[k]);
          nr = 20'(o_r[k]) + 20'(qs);
          e  = 21'(nr) - 21'(p_hold[k]);
          e2 = 42'(e) * 42'(e);
          nr_r[k] <= nr;
          sq_r[k] <= e2[40:0];
        end
      end
      ST_CMP: begin
        if (better) begin
          best_r <= dist_sat;
          bidx_r <= n_r;
          for (int k = 0; k < 3; k++) begin
            bn_r[k] <= nr_r[k];
          end
        end
        n_r <= n_r + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      if (have_r) begin
        out_r.found        <= 1'b1;
        out_r.hit_row      <= 2'(bidx_r / GRID_SIDE);
        out_r.hit_col      <= 2'(bidx_r % GRID_SIDE);
        out_r.near_x       <= sat16(bn_r[0]);
        out_r.near_y       <= sat16(bn_r[1]);
        out_r.near_z       <= sat16(bn_r[2]);
        out_r.best_dist_sq <= best_r;
      end else begin
        out_r <= '0;
      end
    end
  end

endmodule
